FILE: hw/rtl/sss_pkg.sv
// Shared types and constants for the SD SPI sector sequencer.
package sss_pkg;

    // Request command codes
    localparam logic [1:0] CMD_SLOT  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Completion status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_CMD_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_TOK_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_WR_REJECTED = 3'd3;
    localparam logic [2:0] ST_BUSY_TIMEOUT = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_WRITE_GAP   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Register reset values
    localparam logic [9:0] POLL_LIMIT_RST  = 10'd1000;
    localparam logic [9:0] RETRY_LIMIT_RST = 10'd1000;
    localparam logic [7:0] WRITE_GAP_RST   = 8'd100;

    // Bus bytes
    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] TOKEN_START   = 8'hFE;
    localparam logic [7:0] CMD17_BYTE    = 8'h51;
    localparam logic [7:0] CMD24_BYTE    = 8'h58;
    localparam logic [7:0] R1_READY      = 8'h00;
    localparam logic [4:0] DRESP_MASK    = 5'h1F;
    localparam logic [4:0] DRESP_ACCEPT  = 5'h05;

    localparam int FRAME_BYTES = 6;
    localparam int CRC_BYTES   = 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [22:0] sector;
        logic [8:0]  first_offset;
        logic [9:0]  byte_count;
        logic [7:0]  miso_byte;
        logic [7:0]  write_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       chip_select_high;
        logic       slot_request;
        logic       payload_taken;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] status;
    } out_t;

endpackage

FILE: hw/rtl/sss_in_stage.sv
// Input register stage: holds one request until the sequencer takes it.
module sss_in_stage
    import sss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    input  logic take,
    output logic held_valid,
    output in_t  held_data
);

    logic valid_reg;
    logic valid_next;
    in_t  data_reg;
    logic load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: hw/rtl/sss_step.sv
// Sequencer state, configuration registers and per-slot next-state logic.
module sss_step
    import sss_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   fire,
    input  in_t                    item,
    output logic                   produce,
    output out_t                   result
);

    localparam int BPW = $clog2(SECTOR_BYTES + 1);
    localparam int PW  = (BPW > 8) ? BPW : 8;
    localparam int SW  = ((PW > 10) ? PW : 10) + 1;
    localparam logic [PW-1:0] SB_P = PW'(SECTOR_BYTES);
    localparam logic [SW-1:0] SB_S = SW'(SECTOR_BYTES);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_PRE    = 4'd1;
    localparam logic [3:0] PH_FRAME  = 4'd2;
    localparam logic [3:0] PH_DUMMY  = 4'd3;
    localparam logic [3:0] PH_RESP   = 4'd4;
    localparam logic [3:0] PH_GAP    = 4'd5;
    localparam logic [3:0] PH_TOKEN  = 4'd6;
    localparam logic [3:0] PH_WDATA  = 4'd7;
    localparam logic [3:0] PH_WCRC   = 4'd8;
    localparam logic [3:0] PH_WRESP  = 4'd9;
    localparam logic [3:0] PH_BUSY   = 4'd10;
    localparam logic [3:0] PH_RTOKEN = 4'd11;
    localparam logic [3:0] PH_RDATA  = 4'd12;
    localparam logic [3:0] PH_RCRC   = 4'd13;

    logic [9:0]    poll_limit_reg;
    logic [9:0]    retry_limit_reg;
    logic [7:0]    write_gap_reg;

    logic [3:0]    phase_reg,  phase_next;
    logic          is_write_reg, is_write_next;
    logic [47:0]   frame_reg,  frame_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic [9:0]    poll_reg,   poll_next;
    logic [9:0]    retry_reg,  retry_next;
    logic [PW-1:0] pstart_reg, pstart_next;
    logic [PW-1:0] pend_reg,   pend_next;

    logic [PW-1:0] pos_inc;
    logic [9:0]    poll_inc;
    logic [9:0]    retry_inc;
    logic [31:0]   addr;
    logic [SW-1:0] first_s;
    logic [SW-1:0] start_s;
    logic [SW-1:0] end_s;
    logic          in_window;
    logic          rv;
    logic [7:0]    rb;
    logic          done;
    logic [2:0]    st;
    logic [7:0]    mosi;
    logic          taken;

    assign pos_inc   = pos_reg + 1'b1;
    assign poll_inc  = poll_reg + 1'b1;
    assign retry_inc = retry_reg + 1'b1;
    assign addr      = {9'd0, item.sector} * 32'(SECTOR_BYTES);
    assign first_s   = SW'(item.first_offset);
    assign start_s   = (first_s > SB_S) ? SB_S : first_s;
    assign end_s     = start_s + SW'(item.byte_count);
    assign in_window = (pos_reg >= pstart_reg) && (pos_reg < pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg  <= POLL_LIMIT_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
            write_gap_reg   <= WRITE_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_LIMIT:  poll_limit_reg  <= cfg_data;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data;
                CFG_WRITE_GAP:   write_gap_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        frame_next    = frame_reg;
        pos_next      = pos_reg;
        poll_next     = poll_reg;
        retry_next    = retry_reg;
        pstart_next   = pstart_reg;
        pend_next     = pend_reg;
        produce       = 1'b0;
        rv            = 1'b0;
        rb            = 8'd0;
        done          = 1'b0;
        st            = ST_OK;

        if (fire)
        begin
            if (item.command == CMD_READ || item.command == CMD_WRITE)
            begin
                // drop a start request while an operation runs
                if (phase_reg == PH_IDLE)
                begin
                    produce       = 1'b1;
                    is_write_next = (item.command == CMD_WRITE);
                    frame_next    = {(item.command == CMD_WRITE) ? CMD24_BYTE : CMD17_BYTE,
                                     addr, BYTE_IDLE};
                    pstart_next   = PW'(start_s);
                    pend_next     = (end_s > SB_S) ? SB_P : PW'(end_s);
                    retry_next    = 10'd0;
                    poll_next     = 10'd0;
                    pos_next      = '0;
                    phase_next    = PH_PRE;
                end
            end
            else if (item.command == CMD_SLOT && phase_reg != PH_IDLE)
            begin
                produce = 1'b1;
                unique case (phase_reg)
                    PH_PRE:
                    begin
                        phase_next = PH_FRAME;
                        pos_next   = '0;
                    end
                    PH_FRAME:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= PW'(FRAME_BYTES))
                        begin
                            phase_next = PH_DUMMY;
                        end
                    end
                    PH_DUMMY:
                    begin
                        phase_next = PH_RESP;
                        poll_next  = 10'd0;
                    end
                    PH_RESP:
                    begin
                        poll_next = poll_inc;
                        if (item.miso_byte != BYTE_IDLE || poll_inc >= poll_limit_reg)
                        begin
                            if (item.miso_byte == R1_READY)
                            begin
                                if (is_write_reg)
                                begin
                                    pos_next   = '0;
                                    phase_next = (write_gap_reg == 8'd0) ? PH_TOKEN : PH_GAP;
                                end
                                else
                                begin
                                    poll_next  = 10'd0;
                                    phase_next = PH_RTOKEN;
                                end
                            end
                            else
                            begin
                                retry_next = retry_inc;
                                if (retry_inc >= retry_limit_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                    st         = ST_CMD_TIMEOUT;
                                end
                                else
                                begin
                                    phase_next = PH_PRE;
                                end
                            end
                        end
                    end
                    PH_GAP:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= PW'(write_gap_reg))
                        begin
                            phase_next = PH_TOKEN;
                        end
                    end
                    PH_TOKEN:
                    begin
                        pos_next   = '0;
                        phase_next = PH_WDATA;
                    end
                    PH_WDATA:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= SB_P)
                        begin
                            pos_next   = '0;
                            phase_next = PH_WCRC;
                        end
                    end
                    PH_WCRC:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= PW'(CRC_BYTES))
                        begin
                            phase_next = PH_WRESP;
                        end
                    end
                    PH_WRESP:
                    begin
                        if ((item.miso_byte[4:0] & DRESP_MASK) != DRESP_ACCEPT)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            st         = ST_WR_REJECTED;
                        end
                        else
                        begin
                            poll_next  = 10'd0;
                            phase_next = PH_BUSY;
                        end
                    end
                    PH_BUSY:
                    begin
                        poll_next = poll_inc;
                        if (item.miso_byte == BYTE_IDLE)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            st         = ST_OK;
                        end
                        else if (poll_inc >= poll_limit_reg)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            st         = ST_BUSY_TIMEOUT;
                        end
                    end
                    PH_RTOKEN:
                    begin
                        poll_next = poll_inc;
                        if (item.miso_byte == TOKEN_START)
                        begin
                            pos_next   = '0;
                            phase_next = PH_RDATA;
                        end
                        else if (poll_inc >= poll_limit_reg)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            st         = ST_TOK_TIMEOUT;
                        end
                    end
                    PH_RDATA:
                    begin
                        // report only bytes inside the payload window
                        if (in_window)
                        begin
                            rv = 1'b1;
                            rb = item.miso_byte;
                        end
                        pos_next = pos_inc;
                        if (pos_inc >= SB_P)
                        begin
                            pos_next   = '0;
                            phase_next = PH_RCRC;
                        end
                    end
                    PH_RCRC:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= PW'(CRC_BYTES))
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            st         = ST_OK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        produce    = 1'b0;
                    end
                endcase
            end
        end
    end

    // Byte for the next slot follows the updated state
    always_comb
    begin
        mosi  = BYTE_IDLE;
        taken = 1'b0;
        if (phase_next == PH_FRAME)
        begin
            unique case (pos_next[2:0])
                3'd0:    mosi = frame_next[47:40];
                3'd1:    mosi = frame_next[39:32];
                3'd2:    mosi = frame_next[31:24];
                3'd3:    mosi = frame_next[23:16];
                3'd4:    mosi = frame_next[15:8];
                3'd5:    mosi = frame_next[7:0];
                default: mosi = BYTE_IDLE;
            endcase
        end
        else if (phase_next == PH_TOKEN)
        begin
            mosi = TOKEN_START;
        end
        else if (phase_next == PH_WDATA && pos_next >= pstart_next && pos_next < pend_next)
        begin
            mosi  = item.write_byte;
            taken = 1'b1;
        end
    end

    always_comb
    begin
        result.mosi_byte        = mosi;
        result.chip_select_high = (phase_next == PH_IDLE || phase_next == PH_PRE);
        result.slot_request     = (phase_next != PH_IDLE);
        result.payload_taken    = taken;
        result.read_valid       = rv;
        result.read_byte        = rb;
        result.done_res         = done;
        result.status           = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_write_reg <= 1'b0;
            frame_reg    <= '0;
            pos_reg      <= '0;
            poll_reg     <= 10'd0;
            retry_reg    <= 10'd0;
            pstart_reg   <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            is_write_reg <= is_write_next;
            frame_reg    <= frame_next;
            pos_reg      <= pos_next;
            poll_reg     <= poll_next;
            retry_reg    <= retry_next;
            pstart_reg   <= pstart_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

FILE: hw/rtl/sss_out_stage.sv
// Result register stage: holds one result until the receiver takes it.
module sss_out_stage
    import sss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  out_t load_data,
    output logic room,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic valid_reg;
    logic valid_next;
    out_t data_reg;

    assign room      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

FILE: hw/rtl/sd_spi_sector_sequencer_top.sv
// SD SPI-mode single sector read/write sequencer, top level.
//
// Requests enter on in_valid/in_stall with an in_t payload: a start read, a start
// write, or the report of a finished SPI byte slot (the MISO byte and the next
// offered write byte). Each accepted request that the sequencer acts on yields
// one result on out_valid/out_stall: the MOSI byte and chip select level for the
// next slot, whether a slot must follow, a consumed write byte or a captured read
// byte, and done with status on the last result of an operation. Start requests
// during an operation, slot reports while idle and unknown commands are dropped.
// The configuration port (cfg_we, cfg_index, cfg_data) sets poll limit, retry
// limit and write gap; write it only while the sequencer is idle.
// An accepted request is loaded into the input register, then passes through the
// slot logic into the result register, which drives out_valid and out_data. One
// request per cycle is sustained while the receiver does not stall; the slot
// logic is combinational and finishes every request without holding it.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_stall rises. Reset returns the sequencer to idle with the
// register defaults and both stages empty.
module sd_spi_sector_sequencer_top
    import sss_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_t                   out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic held_valid;
    in_t  held_data;
    logic room;
    logic fire;
    logic produce;
    out_t result;

    assign fire = held_valid && room;

    sss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .take       (fire),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    sss_step #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (held_data),
        .produce   (produce),
        .result    (result)
    );

    sss_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (produce),
        .load_data (result),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/sss_checker.sv
// Port-level checks for the sequencer top level, with bind.
module sss_checker
    import sss_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> out_data.status == ST_OK)
        else $error("status set without done");

    // Read and write payload only move with the card selected and slots running
    a_payload_cs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.read_valid || out_data.payload_taken)
            |-> !out_data.chip_select_high && !out_data.done_res)
        else $error("payload with chip select high or at done");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.slot_request
            |-> out_data.done_res && out_data.chip_select_high
                && out_data.mosi_byte == BYTE_IDLE)
        else $error("idle result not a completion with chip select high");

endmodule

bind sd_spi_sector_sequencer_top sss_checker u_sss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: bench/tb.sv
// Self-checking regression bench for the SD SPI sector sequencer top level.
`timescale 1ns / 1ps

module tb;
    import sss_pkg::*;

    localparam int SECTOR        = 512;
    localparam int TOTAL_ITEMS   = 1650;
    localparam int LONG_HOLD     = 60;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_PRE, SQ_FRAME, SQ_DUMMY, SQ_RESP, SQ_GAP, SQ_TOKEN, SQ_WDATA,
        SQ_WCRC, SQ_WRESP, SQ_BUSY, SQ_RTOKEN, SQ_RDATA, SQ_RCRC
    } seq_phase_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the sequencer registers and state
    logic [9:0] poll_limit = POLL_LIMIT_RST;
    logic [9:0] retry_limit = RETRY_LIMIT_RST;
    logic [7:0] gap_cfg = WRITE_GAP_RST;
    seq_phase_e ph = SQ_IDLE;
    bit wr_op = 1'b0;
    logic [47:0] frame = '0;
    int pos = 0;
    int polls = 0;
    int retries = 0;
    int win_lo = 0;
    int win_hi = 0;

    // Card behavior for the current operation
    int resp_delay = 0;
    int bad_answers = 0;
    int token_delay = 0;
    int busy_polls = 0;
    bit accept_data = 1'b1;

    out_t slot_replies_due[$];
    int answered_items = 0;
    int fail_count = 0;
    bit quiet = 1'b0;
    bit long_hold_pending = 1'b0;

    sd_spi_sector_sequencer_top #(.SECTOR_BYTES(SECTOR)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the mirror by one accepted request; queue the reply it causes.
    function automatic bit step_sequencer(in_t r);
        out_t res;
        int lim_poll;
        int lim_retry;
        bit rv;
        bit fin;
        logic [7:0] rb;
        logic [2:0] st;
        rv = 1'b0;
        rb = '0;
        fin = 1'b0;
        st = ST_OK;
        lim_poll = (poll_limit == 0) ? 1 : int'(poll_limit);
        lim_retry = (retry_limit == 0) ? 1 : int'(retry_limit);
        if (r.command == CMD_READ || r.command == CMD_WRITE)
        begin
            if (ph != SQ_IDLE)
                return 1'b0;
            wr_op = (r.command == CMD_WRITE);
            frame = {(wr_op ? CMD24_BYTE : CMD17_BYTE), r.sector, 9'd0, BYTE_IDLE};
            win_lo = (r.first_offset > SECTOR) ? SECTOR : int'(r.first_offset);
            win_hi = win_lo + int'(r.byte_count);
            if (win_hi > SECTOR)
                win_hi = SECTOR;
            retries = 0;
            polls = 0;
            pos = 0;
            ph = SQ_PRE;
        end
        else
        begin
            if (r.command != CMD_SLOT || ph == SQ_IDLE)
                return 1'b0;
            case (ph)
                SQ_PRE:
                begin
                    ph = SQ_FRAME;
                    pos = 0;
                end
                SQ_FRAME:
                begin
                    pos++;
                    if (pos >= FRAME_BYTES)
                        ph = SQ_DUMMY;
                end
                SQ_DUMMY:
                begin
                    ph = SQ_RESP;
                    polls = 0;
                end
                SQ_RESP:
                begin
                    polls++;
                    if (r.miso_byte != BYTE_IDLE || polls >= lim_poll)
                    begin
                        if (r.miso_byte == R1_READY)
                        begin
                            if (wr_op)
                            begin
                                pos = 0;
                                ph = (gap_cfg == 0) ? SQ_TOKEN : SQ_GAP;
                            end
                            else
                            begin
                                polls = 0;
                                ph = SQ_RTOKEN;
                            end
                        end
                        else
                        begin
                            retries++;
                            if (retries >= lim_retry)
                            begin
                                ph = SQ_IDLE;
                                fin = 1'b1;
                                st = ST_CMD_TIMEOUT;
                            end
                            else
                                ph = SQ_PRE;
                        end
                    end
                end
                SQ_GAP:
                begin
                    pos++;
                    if (pos >= int'(gap_cfg))
                        ph = SQ_TOKEN;
                end
                SQ_TOKEN:
                begin
                    pos = 0;
                    ph = SQ_WDATA;
                end
                SQ_WDATA:
                begin
                    pos++;
                    if (pos >= SECTOR)
                    begin
                        pos = 0;
                        ph = SQ_WCRC;
                    end
                end
                SQ_WCRC:
                begin
                    pos++;
                    if (pos >= CRC_BYTES)
                        ph = SQ_WRESP;
                end
                SQ_WRESP:
                begin
                    if ((r.miso_byte[4:0] & DRESP_MASK) != DRESP_ACCEPT)
                    begin
                        ph = SQ_IDLE;
                        fin = 1'b1;
                        st = ST_WR_REJECTED;
                    end
                    else
                    begin
                        polls = 0;
                        ph = SQ_BUSY;
                    end
                end
                SQ_BUSY:
                begin
                    polls++;
                    if (r.miso_byte == BYTE_IDLE)
                    begin
                        ph = SQ_IDLE;
                        fin = 1'b1;
                        st = ST_OK;
                    end
                    else if (polls >= lim_poll)
                    begin
                        ph = SQ_IDLE;
                        fin = 1'b1;
                        st = ST_BUSY_TIMEOUT;
                    end
                end
                SQ_RTOKEN:
                begin
                    polls++;
                    if (r.miso_byte == TOKEN_START)
                    begin
                        pos = 0;
                        ph = SQ_RDATA;
                    end
                    else if (polls >= lim_poll)
                    begin
                        ph = SQ_IDLE;
                        fin = 1'b1;
                        st = ST_TOK_TIMEOUT;
                    end
                end
                SQ_RDATA:
                begin
                    if (pos >= win_lo && pos < win_hi)
                    begin
                        rv = 1'b1;
                        rb = r.miso_byte;
                    end
                    pos++;
                    if (pos >= SECTOR)
                    begin
                        pos = 0;
                        ph = SQ_RCRC;
                    end
                end
                SQ_RCRC:
                begin
                    pos++;
                    if (pos >= CRC_BYTES)
                    begin
                        ph = SQ_IDLE;
                        fin = 1'b1;
                        st = ST_OK;
                    end
                end
                default:
                begin
                    ph = SQ_IDLE;
                    return 1'b0;
                end
            endcase
        end
        res = '0;
        res.mosi_byte = BYTE_IDLE;
        if (ph == SQ_FRAME && pos < FRAME_BYTES)
            res.mosi_byte = frame[8*(5-pos) +: 8];
        else if (ph == SQ_TOKEN)
            res.mosi_byte = TOKEN_START;
        else if (ph == SQ_WDATA && pos >= win_lo && pos < win_hi)
        begin
            res.mosi_byte = r.write_byte;
            res.payload_taken = 1'b1;
        end
        res.chip_select_high = (ph == SQ_IDLE || ph == SQ_PRE);
        res.slot_request = (ph != SQ_IDLE);
        res.read_valid = rv;
        res.read_byte = rb;
        res.done_res = fin;
        res.status = st;
        slot_replies_due.push_back(res);
        return 1'b1;
    endfunction

    // Byte the card sends in the slot now being run, given the mirrored phase.
    function automatic logic [7:0] card_reply();
        logic [7:0] b;
        b = 8'($urandom);
        case (ph)
            SQ_RESP:
                if (polls + 1 <= resp_delay)
                    b = BYTE_IDLE;
                else if (retries < bad_answers)
                    b = 8'($urandom_range(1, 254));
                else
                    b = R1_READY;
            SQ_RTOKEN:
                if (polls + 1 <= token_delay)
                begin
                    if (b == TOKEN_START)
                        b = BYTE_IDLE;
                end
                else
                    b = TOKEN_START;
            SQ_WRESP:
                if (accept_data)
                    b = {b[7:5], DRESP_ACCEPT};
                else if (b[4:0] == DRESP_ACCEPT)
                    b[0] = ~b[0];
            SQ_BUSY:
                if (polls + 1 <= busy_polls)
                begin
                    if (b == BYTE_IDLE)
                        b = 8'h00;
                end
                else
                    b = BYTE_IDLE;
            default: ;
        endcase
        return b;
    endfunction

    function automatic in_t random_req();
        logic [63:0] raw;
        in_t r;
        raw = {$urandom, $urandom};
        r = raw[$bits(in_t)-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t %s mismatch: expected %0h got %0h", $realtime, name, want, got);
        end
    endfunction

    out_t want_reply;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (slot_replies_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t unexpected reply %0h", $realtime, out_data);
            end
            else
            begin
                want_reply = slot_replies_due.pop_front();
                check_field("mosi_byte", 32'(want_reply.mosi_byte),
                            32'(out_data.mosi_byte));
                check_field("chip_select_high", 32'(want_reply.chip_select_high),
                            32'(out_data.chip_select_high));
                check_field("slot_request", 32'(want_reply.slot_request),
                            32'(out_data.slot_request));
                check_field("payload_taken", 32'(want_reply.payload_taken),
                            32'(out_data.payload_taken));
                check_field("read_valid", 32'(want_reply.read_valid),
                            32'(out_data.read_valid));
                check_field("read_byte", 32'(want_reply.read_byte),
                            32'(out_data.read_byte));
                check_field("done_res", 32'(want_reply.done_res),
                            32'(out_data.done_res));
                check_field("status", 32'(want_reply.status), 32'(out_data.status));
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial
    begin : receiver
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 6)
            begin
                n = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one request and hold it until accepted; valid stays high afterwards.
    task automatic send_req(in_t r);
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (in_stall);
        if (step_sequencer(r))
            answered_items++;
    endtask

    // Drop valid and wait until every reply is back and the pipeline is empty.
    task automatic settle_sequencer();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (slot_replies_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        settle_sequencer();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POLL_LIMIT: poll_limit = val;
            CFG_RETRY_LIMIT: retry_limit = val;
            CFG_WRITE_GAP: gap_cfg = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_card(int rd, int ba, int td, bit ok, int bp);
        resp_delay = rd;
        bad_answers = ba;
        token_delay = td;
        accept_data = ok;
        busy_polls = bp;
    endtask

    // Start one operation and play the card until the sequencer goes idle.
    task automatic run_op(logic [1:0] op, logic [22:0] sec, logic [8:0] first,
                          logic [9:0] count);
        in_t r;
        int pick;
        r = random_req();
        r.command = op;
        r.sector = sec;
        r.first_offset = first;
        r.byte_count = count;
        send_req(r);
        while (ph != SQ_IDLE)
        begin
            r = random_req();
            if ($urandom_range(0, 99) < 2)
            begin
                // stray start or unknown command mid-operation: must be dropped
                pick = $urandom_range(0, 2);
                r.command = (pick == 0) ? CMD_READ : (pick == 1) ? CMD_WRITE : CMD_UNKNOWN;
            end
            else
            begin
                r.command = CMD_SLOT;
                r.miso_byte = card_reply();
            end
            send_req(r);
        end
    endtask

    task automatic test_default_registers();
        // default gap of idle bytes, one bad answer, data response rejected
        set_card(2, 1, 0, 1'b0, 0);
        run_op(CMD_WRITE, 23'h7FFFFF, 9'd0, 10'd512);
    endtask

    task automatic test_limit_edges();
        // zero limits behave as one
        write_reg(CFG_POLL_LIMIT, 10'd0);
        write_reg(CFG_RETRY_LIMIT, 10'd0);
        set_card(1, 0, 0, 1'b1, 0);
        run_op(CMD_READ, 23'h2AAAAA, 9'd3, 10'd4);
        write_reg(CFG_POLL_LIMIT, 10'd3);
        write_reg(CFG_RETRY_LIMIT, 10'd4);
        // bad answer on every attempt up to the retry limit
        set_card(0, 4, 0, 1'b1, 0);
        run_op(CMD_WRITE, 23'h0F0F0F, 9'd0, 10'd8);
        // no token within the poll limit
        set_card(0, 0, 4, 1'b1, 0);
        run_op(CMD_READ, 23'h123456, 9'd0, 10'd8);
    endtask

    task automatic test_ignored_requests();
        in_t r;
        settle_sequencer();
        r = random_req();
        r.command = CMD_SLOT;
        send_req(r);
        r = random_req();
        r.command = CMD_UNKNOWN;
        send_req(r);
        r = random_req();
        r.command = CMD_SLOT;
        send_req(r);
        write_reg(CFG_POLL_LIMIT, 10'd2);
        set_card(0, 0, 5, 1'b1, 0);
        run_op(CMD_READ, 23'h00FF00, 9'd0, 10'd0);
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_POLL_LIMIT, 10'd3);
        write_reg(CFG_RETRY_LIMIT, 10'd4);
        // answer on the last poll of the last attempt, token on the last poll
        set_card(2, 3, 2, 1'b1, 0);
        long_hold_pending = 1'b1;
        run_op(CMD_READ, 23'h555555, 9'd17, 10'd40);
    endtask

    task automatic test_random_traffic();
        int pl;
        int rl;
        int cap;
        int kind;
        logic [1:0] op;
        logic [9:0] count;
        logic [7:0] gap;
        while (answered_items < TOTAL_ITEMS)
        begin
            if (answered_items >= TOTAL_ITEMS * 85 / 100)
                quiet = 1'b1;
            if ($urandom_range(0, 99) < 30)
            begin
                write_reg(CFG_POLL_LIMIT, ($urandom_range(0, 19) == 0) ?
                          10'($urandom_range(13, 1023)) : 10'($urandom_range(0, 12)));
                write_reg(CFG_RETRY_LIMIT, 10'($urandom_range(0, 8)));
                gap = ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(0, 20));
                // upper data bits fall outside the gap register
                write_reg(CFG_WRITE_GAP, {2'($urandom), gap});
            end
            pl = (poll_limit == 0) ? 1 : int'(poll_limit);
            rl = (retry_limit == 0) ? 1 : int'(retry_limit);
            cap = (pl < 12) ? pl : 12;
            kind = $urandom_range(0, 9);
            op = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            count = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 16));
            set_card($urandom_range(0, cap + 1), $urandom_range(0, rl),
                     $urandom_range(0, cap + 1), $urandom_range(0, 3) != 0,
                     $urandom_range(0, cap + 1));
            if (kind < 3)
            begin
                // keep the command from ever completing
                bad_answers = rl + 1;
            end
            else if (kind < 5)
            begin
                op = CMD_READ;
                token_delay = pl + 1;
            end
            run_op(op, 23'($urandom), 9'($urandom), count);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_limit_edges();
        test_ignored_requests();
        test_output_backpressure();
        test_random_traffic();
        quiet = 1'b1;
        settle_sequencer();
        if (slot_replies_due.size() != 0)
        begin
            $display("%0d replies never arrived", slot_replies_due.size());
            fail_count += slot_replies_due.size();
        end
        if (fail_count == 0)
            $display("sd_spi_sector_sequencer_top regression: pass");
        else
            $display("sd_spi_sector_sequencer_top regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("sd_spi_sector_sequencer_top regression: fail");
        $finish;
    end

endmodule
